// ===== hw/rtl/set_assoc_cache_lru_sim_core_defines.svh =====
// Assertion macros used by the checker file of the cache lookup block.
// Depends on nothing; the including module must declare clk and arst_n.
`ifndef SET_ASSOC_CACHE_LRU_SIM_CORE_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_SIM_CORE_DEFINES_SVH

// Implication checked in the same cycle, disabled while in reset.
`define SACL_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked a fixed number of cycles later, disabled while in reset.
`define SACL_ASSERT_LATER(name, ante, n, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) else $error(msg);

`endif

// ===== hw/rtl/sacl_pkg.sv =====
// Shared constants and types of the cache lookup block.
// No dependencies; imported by every RTL module of the block but sacl_ram.
package sacl_pkg;

	localparam int ADDR_W      = 64;
	localparam int SET_CFG_W   = 3;
	localparam int WAYS_CFG_W  = 3;
	localparam int BLOCK_CFG_W = 6;
	localparam int CFG_DATA_W  = 6;
	localparam int CFG_IDX_W   = 2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

	localparam logic [SET_CFG_W-1:0]   SET_BITS_RST   = 3'd4;
	localparam logic [WAYS_CFG_W-1:0]  WAYS_USED_RST  = 3'd1;
	localparam logic [BLOCK_CFG_W-1:0] BLOCK_BITS_RST = 6'd4;

	// way field sized for the largest supported associativity
	localparam int WAY_FIELD_W = 4;

	typedef struct packed {
		logic                   hit;
		logic                   evict;
		logic [WAY_FIELD_W-1:0] way;
	} sacl_decision_t;

endpackage

// ===== hw/rtl/set_assoc_cache_lru_sim_core.sv =====
// Set-associative cache lookup with true LRU replacement and saturating counters.
// Depends on sacl_pkg, sacl_ram, sacl_addr_split and sacl_lru_update.
//
// Usage:
//   Input: drive address and raise start; a transaction is taken at each rising
//   edge with start high and busy low. busy never rises, so one access may be
//   taken every cycle, back to back.
//   Output: each access gives one result. done is high for exactly one cycle,
//   registered after the lookup stage, with hit, miss, evicted, set_index,
//   way_used and the three running totals (after this access). The receiver
//   cannot stall; a result not taken in its cycle is gone.
//   Throughput is one access per cycle, with a single read port on each of the tag
//   and age RAMs and the compare and update done in the lookup stage.
//   A back-to-back access to the same set sees the previous update through a
//   one-entry bypass around the RAMs.
//   Configuration: cfg_wr_en, cfg_index, cfg_data write set_bits, ways_used and
//   block_bits at the next edge; write only while no access is in flight.
//   Reset (arst_n low): all lines invalid, counters zero, configuration back to
//   set_bits 4, ways_used 1, block_bits 4. No clearing pass: ready at once.
module set_assoc_cache_lru_sim_core
	import sacl_pkg::*;
#(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 4,
	parameter int COUNT_BITS   = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [ADDR_W-1:0]       address,
	input  logic                    cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output logic                    done,
	output logic                    hit,
	output logic                    miss,
	output logic                    evicted,
	output logic [MAX_SET_BITS-1:0] set_index,
	output logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] way_used,
	output logic [COUNT_BITS-1:0]   hit_total,
	output logic [COUNT_BITS-1:0]   miss_total,
	output logic [COUNT_BITS-1:0]   evict_total
);

	localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int TAG_ROW_W = MAX_WAYS * ADDR_W;
	localparam int AGE_ROW_W = MAX_WAYS * WAY_W;

	// configuration
	logic [SET_CFG_W-1:0]   set_bits_q;
	logic [WAYS_CFG_W-1:0]  ways_used_q;
	logic [BLOCK_CFG_W-1:0] block_bits_q;

	// accept side
	logic                    accept;
	logic [MAX_SET_BITS-1:0] set_in;
	logic [ADDR_W-1:0]       tag_in;

	// lookup stage
	logic                    vld_s1;
	logic [MAX_SET_BITS-1:0] set_s1;
	logic [ADDR_W-1:0]       tag_s1;

	logic [MAX_WAYS-1:0][ADDR_W-1:0] ram_tags;
	logic [MAX_WAYS-1:0][WAY_W-1:0]  ram_ages;
	logic [MAX_WAYS-1:0][ADDR_W-1:0] row_tags;
	logic [MAX_WAYS-1:0][WAY_W-1:0]  row_ages;
	logic [MAX_WAYS-1:0][ADDR_W-1:0] new_tags;
	logic [MAX_WAYS-1:0][WAY_W-1:0]  new_ages;
	logic [MAX_WAYS-1:0]             new_vld;
	logic                            use_fwd;
	sacl_decision_t                  decision;

	// bypass of the write made at the edge that also read the RAMs
	logic                            fwd_vld_q;
	logic [MAX_SET_BITS-1:0]         fwd_set_q;
	logic [MAX_WAYS-1:0][ADDR_W-1:0] fwd_tags_q;
	logic [MAX_WAYS-1:0][WAY_W-1:0]  fwd_ages_q;

	logic [MAX_WAYS-1:0] line_vld_q [NUM_SETS];

	logic [COUNT_BITS-1:0] hit_cnt_q;
	logic [COUNT_BITS-1:0] miss_cnt_q;
	logic [COUNT_BITS-1:0] evict_cnt_q;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= SET_BITS_RST;
			ways_used_q  <= WAYS_USED_RST;
			block_bits_q <= BLOCK_BITS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SET_BITS:   set_bits_q   <= cfg_data[SET_CFG_W-1:0];
				CFG_WAYS_USED:  ways_used_q  <= cfg_data[WAYS_CFG_W-1:0];
				CFG_BLOCK_BITS: block_bits_q <= cfg_data[BLOCK_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	sacl_addr_split #(
		.MAX_SET_BITS(MAX_SET_BITS)
	) u_split (
		.address   (address),
		.set_bits  (set_bits_q),
		.block_bits(block_bits_q),
		.set_idx   (set_in),
		.tag       (tag_in)
	);

	// the RAMs are read at the accepting edge, written at the end of the lookup cycle
	sacl_ram #(
		.WIDTH(TAG_ROW_W),
		.DEPTH(NUM_SETS)
	) u_tag_ram (
		.clk  (clk),
		.we   (vld_s1),
		.waddr(set_s1),
		.wdata(new_tags),
		.raddr(set_in),
		.rdata(ram_tags)
	);

	sacl_ram #(
		.WIDTH(AGE_ROW_W),
		.DEPTH(NUM_SETS)
	) u_age_ram (
		.clk  (clk),
		.we   (vld_s1),
		.waddr(set_s1),
		.wdata(new_ages),
		.raddr(set_in),
		.rdata(ram_ages)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1 <= set_in;
			tag_s1 <= tag_in;
		end
	end

	// take the bypass when the previous access updated this same set
	assign use_fwd  = fwd_vld_q && (fwd_set_q == set_s1);
	assign row_tags = use_fwd ? fwd_tags_q : ram_tags;
	assign row_ages = use_fwd ? fwd_ages_q : ram_ages;

	sacl_lru_update #(
		.MAX_WAYS(MAX_WAYS)
	) u_lru (
		.ways_used(ways_used_q),
		.tag      (tag_s1),
		.line_vld (line_vld_q[set_s1]),
		.row_tags (row_tags),
		.row_ages (row_ages),
		.decision (decision),
		.new_vld  (new_vld),
		.new_tags (new_tags),
		.new_ages (new_ages)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else begin
			fwd_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			fwd_set_q  <= set_s1;
			fwd_tags_q <= new_tags;
			fwd_ages_q <= new_ages;
		end
	end

	// valid bits in flops so that reset invalidates every line at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SETS; i++) begin
				line_vld_q[i] <= '0;
			end
		end else if (vld_s1) begin
			line_vld_q[set_s1] <= new_vld;
		end
	end

	// saturating counters: hold at all ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
		end else if (vld_s1) begin
			if (decision.hit && hit_cnt_q != '1) begin
				hit_cnt_q <= hit_cnt_q + 1'b1;
			end
			if (!decision.hit && miss_cnt_q != '1) begin
				miss_cnt_q <= miss_cnt_q + 1'b1;
			end
			if (decision.evict && evict_cnt_q != '1) begin
				evict_cnt_q <= evict_cnt_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			hit       <= decision.hit;
			miss      <= ~decision.hit;
			evicted   <= decision.evict;
			set_index <= set_s1;
			way_used  <= decision.way[WAY_W-1:0];
		end
	end

	assign hit_total   = hit_cnt_q;
	assign miss_total  = miss_cnt_q;
	assign evict_total = evict_cnt_q;

endmodule

// ===== hw/rtl/sacl_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies. Read of the address being written returns the old contents.
module sacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/sacl_addr_split.sv =====
// Address split: set index and tag from a byte address and the configuration.
// Depends on sacl_pkg.
module sacl_addr_split
	import sacl_pkg::*;
#(
	parameter int MAX_SET_BITS = 6
) (
	input  logic [ADDR_W-1:0]      address,
	input  logic [SET_CFG_W-1:0]   set_bits,
	input  logic [BLOCK_CFG_W-1:0] block_bits,
	output logic [MAX_SET_BITS-1:0] set_idx,
	output logic [ADDR_W-1:0]      tag
);

	localparam int SUM_W = BLOCK_CFG_W + 1;

	logic [SET_CFG_W-1:0]    s_eff;
	logic [ADDR_W-1:0]       shifted;
	logic [MAX_SET_BITS-1:0] set_mask;
	logic [SUM_W-1:0]        tag_shift;

	always_comb begin
		s_eff     = (32'(set_bits) > MAX_SET_BITS) ? SET_CFG_W'(MAX_SET_BITS) : set_bits;
		shifted   = address >> block_bits;
		set_mask  = ~({MAX_SET_BITS{1'b1}} << s_eff);
		set_idx   = shifted[MAX_SET_BITS-1:0] & set_mask;
		tag_shift = SUM_W'(block_bits) + SUM_W'(s_eff);
		// all bits consumed by offset and set: tag reads as zero
		tag       = (tag_shift >= SUM_W'(ADDR_W)) ? '0 : (address >> tag_shift);
	end

endmodule

// ===== hw/rtl/sacl_lru_update.sv =====
// Per-set lookup and true-LRU replacement: compares all ways in parallel,
// picks the hit, free or victim way and returns the updated set row. Uses sacl_pkg.
module sacl_lru_update
	import sacl_pkg::*;
#(
	parameter int MAX_WAYS = 4
) (
	input  logic [WAYS_CFG_W-1:0]                                  ways_used,
	input  logic [ADDR_W-1:0]                                      tag,
	input  logic [MAX_WAYS-1:0]                                    line_vld,
	input  logic [MAX_WAYS-1:0][ADDR_W-1:0]                        row_tags,
	input  logic [MAX_WAYS-1:0][(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] row_ages,
	output sacl_decision_t                                         decision,
	output logic [MAX_WAYS-1:0]                                    new_vld,
	output logic [MAX_WAYS-1:0][ADDR_W-1:0]                        new_tags,
	output logic [MAX_WAYS-1:0][(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] new_ages
);

	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam logic [WAY_W-1:0] AGE_MAX = WAY_W'(MAX_WAYS - 1);

	logic [MAX_WAYS-1:0]             in_use;
	logic [MAX_WAYS-1:0]             match;
	logic [MAX_WAYS-1:0]             free;
	logic [MAX_WAYS-1:0]             cand;
	logic [MAX_WAYS-1:0][WAY_W-1:0]  age;
	logic [WAY_W-1:0]                hit_way;
	logic [WAY_W-1:0]                free_way;
	logic [WAY_W-1:0]                victim;
	logic [WAY_W-1:0]                way;
	logic [WAY_W-1:0]                limit;
	logic                            hit;
	logic                            any_free;
	logic                            no_limit;

	always_comb begin
		for (int i = 0; i < MAX_WAYS; i++) begin
			in_use[i] = (i == 0) || (32'(ways_used) > i);
			// a line never filled holds its reset age of zero
			age[i]    = line_vld[i] ? row_ages[i] : '0;
			match[i]  = in_use[i] & line_vld[i] & (row_tags[i] == tag);
			free[i]   = in_use[i] & ~line_vld[i];
		end

		// victim: greatest age, lowest way on a tie
		for (int i = 0; i < MAX_WAYS; i++) begin
			cand[i] = in_use[i];
			for (int j = 0; j < MAX_WAYS; j++) begin
				if (in_use[j] && j < i && age[j] >= age[i]) begin
					cand[i] = 1'b0;
				end
				if (in_use[j] && j > i && age[j] > age[i]) begin
					cand[i] = 1'b0;
				end
			end
		end

		hit_way  = '0;
		free_way = '0;
		victim   = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_way = WAY_W'(i);
			end
			if (free[i]) begin
				free_way = WAY_W'(i);
			end
			if (cand[i]) begin
				victim = WAY_W'(i);
			end
		end

		hit      = |match;
		any_free = |free;

		if (hit) begin
			way      = hit_way;
			no_limit = 1'b0;
		end else if (any_free) begin
			way      = free_way;
			no_limit = 1'b1;
		end else begin
			way      = victim;
			no_limit = 1'b0;
		end
		limit = age[way];

		for (int i = 0; i < MAX_WAYS; i++) begin
			new_tags[i] = row_tags[i];
			new_ages[i] = age[i];
			new_vld[i]  = line_vld[i];
			if (WAY_W'(i) == way) begin
				new_ages[i] = '0;
				if (!hit) begin
					new_tags[i] = tag;
					new_vld[i]  = 1'b1;
				end
			end else if (in_use[i] && line_vld[i] && (no_limit || age[i] < limit)
					&& age[i] < AGE_MAX) begin
				new_ages[i] = age[i] + 1'b1;
			end
		end

		decision.hit   = hit;
		decision.evict = ~hit & ~any_free;
		decision.way   = WAY_FIELD_W'(way);
	end

endmodule

// ===== hw/rtl/sacl_checker.sv =====
// Port-level checks of the cache lookup block, bound to its top level.
// Depends on sacl_pkg and set_assoc_cache_lru_sim_core_defines.svh.
`include "set_assoc_cache_lru_sim_core_defines.svh"

module sacl_checker
	import sacl_pkg::*;
#(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 4,
	parameter int COUNT_BITS   = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  done,
	input logic                  hit,
	input logic                  miss,
	input logic                  evicted,
	input logic [COUNT_BITS-1:0] miss_total,
	input logic [COUNT_BITS-1:0] evict_total
);

	// each accepted transaction yields exactly one result, and no result comes without one
	`SACL_ASSERT_LATER(a_result_follows, start && !busy, 2, done, "accepted access gave no result")
	`SACL_ASSERT_LATER(a_no_spurious, !(start && !busy), 2, !done, "result without an access")
	`SACL_ASSERT_NOW(a_hit_xor_miss, done, hit != miss, "hit and miss not exclusive")
	`SACL_ASSERT_NOW(a_evict_on_miss, done && evicted, miss && evict_total <= miss_total,
		"eviction without a miss")

endmodule

bind set_assoc_cache_lru_sim_core sacl_checker #(
	.MAX_SET_BITS(MAX_SET_BITS),
	.MAX_WAYS    (MAX_WAYS),
	.COUNT_BITS  (COUNT_BITS)
) u_sacl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.hit        (hit),
	.miss       (miss),
	.evicted    (evicted),
	.miss_total (miss_total),
	.evict_total(evict_total)
);

// ===== test/tb.sv =====
// Testbench for the set-associative cache lookup core with true LRU replacement.
// Drives directed and random access traffic; a local predictor checks every result.
// Depends on sacl_pkg and set_assoc_cache_lru_sim_core.
`timescale 1ns / 100ps

module tb;
	import sacl_pkg::*;

	localparam int MAX_SET_BITS = 6;
	localparam int MAX_WAYS     = 4;
	localparam int COUNT_BITS   = 32;
	localparam int NUM_LINES    = (1 << MAX_SET_BITS) * MAX_WAYS;
	localparam int AGE_MAX      = MAX_WAYS - 1;

	// index 3 decodes to no register; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	// one expected lookup outcome, field widths as on the result ports
	typedef struct packed {
		logic                    hit;
		logic                    miss;
		logic                    evicted;
		logic [MAX_SET_BITS-1:0] set_index;
		logic [1:0]              way_used;
		logic [COUNT_BITS-1:0]   hit_total;
		logic [COUNT_BITS-1:0]   miss_total;
		logic [COUNT_BITS-1:0]   evict_total;
	} lookup_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic [ADDR_W-1:0]       address = '0;
	logic                    cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    busy;
	logic                    done;
	logic                    hit;
	logic                    miss;
	logic                    evicted;
	logic [MAX_SET_BITS-1:0] set_index;
	logic [1:0]              way_used;
	logic [COUNT_BITS-1:0]   hit_total;
	logic [COUNT_BITS-1:0]   miss_total;
	logic [COUNT_BITS-1:0]   evict_total;

	// predictor copy of the cache state and the geometry registers
	bit                    way_valid [NUM_LINES];
	logic [63:0]           way_tag [NUM_LINES];
	int                    way_age [NUM_LINES];
	logic [COUNT_BITS-1:0] tally_hit = '0;
	logic [COUNT_BITS-1:0] tally_miss = '0;
	logic [COUNT_BITS-1:0] tally_evict = '0;
	logic [2:0]            geo_set_bits = SET_BITS_RST;
	logic [2:0]            geo_ways = WAYS_USED_RST;
	logic [5:0]            geo_block_bits = BLOCK_BITS_RST;

	lookup_result_t expected_lookups [$];
	int             errors = 0;
	bit             gap_on = 1'b1;

	set_assoc_cache_lru_sim_core #(
		.MAX_SET_BITS(MAX_SET_BITS),
		.MAX_WAYS    (MAX_WAYS),
		.COUNT_BITS  (COUNT_BITS)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.address    (address),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.done       (done),
		.hit        (hit),
		.miss       (miss),
		.evicted    (evicted),
		.set_index  (set_index),
		.way_used   (way_used),
		.hit_total  (hit_total),
		.miss_total (miss_total),
		.evict_total(evict_total)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Hard stop well beyond the slowest legal run (about 525 accesses with long gaps).
	initial begin
		#2_000_000;
		$display("tb: done, errors");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// set_bits above the supported maximum clamp to the maximum
	function automatic int eff_set_bits();
		return (geo_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(geo_set_bits);
	endfunction

	function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Make one way most recent; age every other valid in-use way younger than limit,
	// holding at the oldest age.
	function automatic void age_lines(input int base, input int nways, input int way,
			input int limit);
		int i;
		for (i = 0; i < nways; i++)
			if (i != way && way_valid[base + i] && way_age[base + i] < limit &&
					way_age[base + i] < AGE_MAX)
				way_age[base + i]++;
		way_age[base + way] = 0;
	endfunction

	// Look one address up in the predictor cache, update it, return the outcome.
	function automatic lookup_result_t predict_lookup(input logic [63:0] a);
		lookup_result_t r;
		int             s, nways, b, base, way, i;
		logic [63:0]    set_no, tg;
		bit             found;
		s = eff_set_bits();
		nways = (geo_ways == 0) ? 1 : ((geo_ways > MAX_WAYS) ? MAX_WAYS : int'(geo_ways));
		b = int'(geo_block_bits);
		set_no = (a >> b) & ((64'd1 << s) - 64'd1);
		// offset plus index covering the whole address leaves an empty tag
		tg = (s + b >= 64) ? 64'd0 : (a >> (s + b));
		base = int'(set_no) * MAX_WAYS;
		r = '0;
		found = 1'b0;
		way = 0;
		for (i = 0; i < nways && !found; i++)
			if (way_valid[base + i] && way_tag[base + i] == tg) begin
				found = 1'b1;
				way = i;
			end
		if (found) begin
			r.hit = 1'b1;
			tally_hit = count_up(tally_hit);
			age_lines(base, nways, way, way_age[base + way]);
		end else begin
			r.miss = 1'b1;
			tally_miss = count_up(tally_miss);
			for (i = 0; i < nways && !found; i++)
				if (!way_valid[base + i]) begin
					found = 1'b1;
					way = i;
				end
			if (found) begin
				way_valid[base + way] = 1'b1;
				way_tag[base + way] = tg;
				age_lines(base, nways, way, AGE_MAX + 1);
			end else begin
				// oldest way wins; the lowest way number breaks a tie
				way = 0;
				for (i = 1; i < nways; i++)
					if (way_age[base + i] > way_age[base + way])
						way = i;
				r.evicted = 1'b1;
				tally_evict = count_up(tally_evict);
				way_tag[base + way] = tg;
				age_lines(base, nways, way, way_age[base + way]);
			end
		end
		r.set_index = set_no[MAX_SET_BITS-1:0];
		r.way_used = way[1:0];
		r.hit_total = tally_hit;
		r.miss_total = tally_miss;
		r.evict_total = tally_evict;
		return r;
	endfunction

	// Build an address from tag, set and offset under the current geometry.
	function automatic logic [63:0] compose_address(input logic [63:0] tg,
			input logic [63:0] set_no, input logic [63:0] off);
		int s, b;
		s = eff_set_bits();
		b = int'(geo_block_bits);
		off &= (64'd1 << b) - 64'd1;
		set_no &= (64'd1 << s) - 64'd1;
		return off | (set_no << b) | ((s + b >= 64) ? 64'd0 : (tg << (s + b)));
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	function automatic void check_field(input string fname, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (act_v !== exp_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h",
				$time, fname, exp_v, act_v);
		end
	endfunction

	function automatic void check_result();
		lookup_result_t e;
		if (expected_lookups.size() == 0) begin
			errors++;
			$display("%0t: result strobe with no access outstanding", $time);
			return;
		end
		e = expected_lookups.pop_front();
		check_field("hit", 64'(e.hit), 64'(hit));
		check_field("miss", 64'(e.miss), 64'(miss));
		check_field("evicted", 64'(e.evicted), 64'(evicted));
		check_field("set_index", 64'(e.set_index), 64'(set_index));
		check_field("way_used", 64'(e.way_used), 64'(way_used));
		check_field("hit_total", 64'(e.hit_total), 64'(hit_total));
		check_field("miss_total", 64'(e.miss_total), 64'(miss_total));
		check_field("evict_total", 64'(e.evict_total), 64'(evict_total));
	endfunction

	// Sample at each rising edge, before the core's flops update: retire a result
	// strobe against the oldest expectation, then predict any transaction taken
	// at this edge.
	always @(posedge clk) begin
		if (arst_n && done)
			check_result();
		if (arst_n && start && !busy)
			expected_lookups.push_back(predict_lookup(address));
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offer one access and hold it until the core takes it. Insert an idle gap
	// first on about one access in four; about one gap in ten is a long one.
	task automatic send_access(input logic [63:0] a);
		int gap;
		if (gap_on && $urandom_range(0, 3) == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		address <= a;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Drop start and hold off until every outstanding result has come back,
	// plus an idle margin after the last one.
	task automatic wait_for_drain();
		start <= 1'b0;
		while (expected_lookups.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// One register write; leaves the write enable high for a following write.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_SET_BITS:   geo_set_bits = data[2:0];
			CFG_WAYS_USED:  geo_ways = data[2:0];
			CFG_BLOCK_BITS: geo_block_bits = data[5:0];
			default: ;
		endcase
	endtask

	// Reprogram all three geometry registers with the core idle.
	task automatic write_geometry(input logic [5:0] set_val, input logic [5:0] ways_val,
			input logic [5:0] block_val);
		wait_for_drain();
		write_register(CFG_SET_BITS, set_val);
		write_register(CFG_WAYS_USED, ways_val);
		write_register(CFG_BLOCK_BITS, block_val);
		cfg_wr_en <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset geometry is direct mapped: fill, hit, a conflict eviction, then fills of two other sets.
	task automatic test_reset_geometry();
		send_access(64'd0);
		send_access(64'd0);
		send_access(64'h100);
		send_access(64'hAAAA_AAAA_AAAA_AAAA);
		send_access('1);
	endtask

	// Four ways in one set: fill in order, promote a hit, check the LRU victim.
	task automatic test_lru_order();
		int t;
		write_geometry(6'd2, 6'd4, 6'd4);
		for (t = 1; t <= 4; t++)
			send_access(compose_address(64'(t), 64'd1, 64'd0));
		send_access(compose_address(64'd1, 64'd1, 64'd5));
		send_access(compose_address(64'd5, 64'd1, 64'd0));
		send_access(compose_address(64'd3, 64'd1, 64'd0));
		send_access(compose_address(64'd6, 64'd1, 64'd0));
	endtask

	// Shrink and regrow the associativity: unused ways keep their lines and ages,
	// zero ways acts as one, and too many ways clamps to the maximum.
	task automatic test_way_change();
		gap_on = 1'b0;
		write_geometry(6'd2, 6'd2, 6'd4);
		send_access(compose_address(64'd7, 64'd1, 64'd0));
		send_access(compose_address(64'd8, 64'd1, 64'd0));
		write_geometry(6'd2, 6'd0, 6'd4);
		send_access(compose_address(64'd4, 64'd1, 64'd0));
		write_geometry(6'd2, 6'd7, 6'd4);
		send_access(compose_address(64'd4, 64'd1, 64'd0));
		send_access(compose_address(64'd9, 64'd1, 64'd0));
		gap_on = 1'b1;
	endtask

	// Offsets wide enough to swallow the tag, oversized set_bits, a single set,
	// and a write to the unused register index.
	task automatic test_wide_offset();
		wait_for_drain();
		write_register(CFG_SPARE, 6'($urandom_range(0, 63)));
		cfg_wr_en <= 1'b0;
		write_geometry(6'd6, 6'd4, 6'd58);
		send_access('1);
		send_access(64'd0);
		send_access(64'h5555_5555_5555_5555);
		write_geometry(6'd7, 6'd4, 6'd63);
		send_access('1);
		send_access(64'h7FFF_FFFF_FFFF_FFFF);
		write_geometry(6'd0, 6'd1, 6'd0);
		send_access(64'd0);
		send_access(64'd1);
	endtask

	// Phases of random traffic, each under its own geometry. Most accesses reuse
	// a small pool of tags over a few sets so hits and evictions are common; the
	// rest are fully random addresses. Unused high data bits of the narrow
	// registers are randomized.
	task automatic test_random_traffic();
		logic [63:0] tag_pool [6];
		int          p, n, k;
		for (p = 0; p < 10; p++) begin
			case (p)
				0: write_geometry(6'd0, 6'd1, 6'd0);
				1: write_geometry(6'd6, 6'd4, 6'd0);
				2: write_geometry(6'd7, 6'd7, 6'd63);
				3: write_geometry(6'd6, 6'd4, 6'd58);
				4: write_geometry(6'd2, 6'd0, 6'd59);
				default:
					write_geometry(6'(($urandom_range(0, 7) << 3) | $urandom_range(0, 7)),
						6'(($urandom_range(0, 7) << 3) | $urandom_range(0, 7)),
						6'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
							: $urandom_range(0, 12)));
			endcase
			for (k = 0; k < 6; k++)
				tag_pool[k] = $urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 7));
			// run every third phase back to back with no idle cycles
			gap_on = (p % 3 != 1);
			for (n = 0; n < 50; n++) begin
				// pause mid-phase until the core has answered everything
				if (p == 5 && n == 25)
					wait_for_drain();
				if ($urandom_range(0, 99) < 85)
					send_access(compose_address(tag_pool[$urandom_range(0, 5)],
						64'($urandom_range(0, 3)), rand64()));
				else
					send_access(rand64());
			end
		end
		gap_on = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		int guard;
		foreach (way_valid[i]) begin
			way_valid[i] = 1'b0;
			way_tag[i] = '0;
			way_age[i] = 0;
		end
		// hold reset from time zero, release it at an edge
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_geometry();
		test_lru_order();
		test_way_change();
		test_wide_offset();
		test_random_traffic();

		// let the last results come back, bounded
		start <= 1'b0;
		for (guard = 0; guard < 200 && expected_lookups.size() != 0; guard++)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (expected_lookups.size() != 0) begin
			errors += expected_lookups.size();
			$display("%0t: %0d results never arrived", $time, expected_lookups.size());
		end
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/sacl_pkg.sv
hw/rtl/sacl_ram.sv
hw/rtl/sacl_addr_split.sv
hw/rtl/sacl_lru_update.sv
hw/rtl/set_assoc_cache_lru_sim_core.sv
hw/rtl/sacl_checker.sv
test/tb.sv
